>>> design/bfe_pkg.sv
// Package for the bloom filter engine: payload structs, mode codes and hash constants.
// No dependencies.
`timescale 1ns / 1ps
package bfe_pkg;
    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_QUERY = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;
    localparam logic [2:0] ADDR_BIT_COUNT  = 3'd0;
    localparam logic [2:0] ADDR_NUM_HASHES = 3'd4;
    localparam logic [63:0] FNV_PRIME = 64'd1099511628211;
    localparam logic [63:0] SEED_A = 64'h0000_0000_1234_5678;
    localparam logic [63:0] SEED_B = 64'h0000_0000_8765_4321;
    localparam logic [16:0] RESET_BIT_COUNT = 17'd65536;
    localparam logic [4:0] RESET_NUM_HASHES = 5'd1;

    typedef struct packed {
        logic [7:0] key_byte;
        logic       last;
        logic [1:0] mode;
    } in_item_t;

    typedef struct packed {
        logic       possibly_present;
        logic [1:0] op_done;
    } out_item_t;

    // multiply by the FNV prime (2^40 + 0x1B3) with shifts and adds, mod 2^64
    function automatic logic [63:0] fnv_mul(input logic [63:0] x);
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction
endpackage

>>> design/bfe_mod_unit.sv
// Iterative unsigned modulo: 64-bit dividend by a narrow divisor, one bit a cycle.
// Depends on nothing but its parameter.
`timescale 1ns / 1ps
module bfe_mod_unit #(
    parameter int MW = 17
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [63:0]   dividend,
    input  logic [MW-1:0] divisor,
    output logic          done,
    output logic [MW-1:0] remainder
);
    logic [63:0] dvd_reg, dvd_next;
    logic [MW:0] rem_reg, rem_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [MW:0] trial;

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[MW-1:0], dvd_reg[63]};
        if (start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
                rem_next = trial - {1'b0, divisor};
            else
                rem_next = trial;
            dvd_next = {dvd_reg[62:0], 1'b0};
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg[MW-1:0];
endmodule

>>> design/bloom_filter_engine.sv
// Top level of the bloom filter engine: APB registers, FNV hashing, bit store sequencer.
// Depends on bfe_pkg and bfe_mod_unit.
`timescale 1ns / 1ps
// Non-last key bytes are hashed in S_IDLE without leaving it. A last byte runs, per
// derived index, a bit-serial 64-bit modulo, then a read-modify-write of one store
// word. Clear sweeps the store one word a cycle. After reset the same sweep runs
// before any item is taken.
module bloom_filter_engine #(
    parameter int MAX_BITS   = 65536,
    parameter int MAX_HASHES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bfe_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output bfe_pkg::out_item_t out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    localparam int WORDS = (MAX_BITS + 63) / 64;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BW    = $clog2(MAX_BITS + 1);
    localparam int HW    = $clog2(MAX_HASHES + 1);
    localparam logic [AW:0] WORDS_L = (AW + 1)'(WORDS);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_MOD    = 6'b000100,
        S_READ   = 6'b001000,
        S_WRITE  = 6'b010000,
        S_OUT    = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [16:0] bit_count_reg;
    logic [4:0]  num_hashes_reg;
    logic [63:0] hash_a_reg, hash_a_next, hash_b_reg, hash_b_next;
    logic [63:0] sum_reg, sum_next;
    logic [HW-1:0] idx_reg, idx_next;
    logic [AW:0] clr_reg, clr_next;
    logic [1:0]  mode_reg, mode_next;
    logic        all_reg, all_next;
    logic [BW-1:0] rem_reg, rem_next;
    logic        ov_reg, ov_next;
    bfe_pkg::out_item_t od_reg, od_next;
    logic [63:0] mem [WORDS];
    logic [63:0] rd_reg;
    logic        we;
    logic [AW-1:0] waddr;
    logic [63:0] wdata;
    logic [63:0] mul_a, mul_b;
    logic [BW-1:0] eff_bits;
    logic [HW-1:0] eff_hashes;
    logic        mod_start, mod_done;
    logic [BW-1:0] mod_rem;
    logic        take;
    logic [63:0] bitmask;

    always_comb
    begin
        if (bit_count_reg == 17'd0)
            eff_bits = BW'(1);
        else if (32'(bit_count_reg) > MAX_BITS)
            eff_bits = BW'(MAX_BITS);
        else
            eff_bits = BW'(bit_count_reg);
        if (num_hashes_reg == 5'd0)
            eff_hashes = HW'(1);
        else if (32'(num_hashes_reg) > MAX_HASHES)
            eff_hashes = HW'(MAX_HASHES);
        else
            eff_hashes = HW'(num_hashes_reg);
    end

    assign pready = 1'b1;
    always_comb
    begin
        unique case (paddr)
            bfe_pkg::ADDR_BIT_COUNT:  prdata = {15'd0, bit_count_reg};
            bfe_pkg::ADDR_NUM_HASHES: prdata = {27'd0, num_hashes_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_count_reg  <= bfe_pkg::RESET_BIT_COUNT;
            num_hashes_reg <= bfe_pkg::RESET_NUM_HASHES;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == bfe_pkg::ADDR_BIT_COUNT)
                bit_count_reg <= pwdata[16:0];
            else if (paddr == bfe_pkg::ADDR_NUM_HASHES)
                num_hashes_reg <= pwdata[4:0];
        end
    end

    bfe_mod_unit #(.MW(BW)) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (sum_next),
        .divisor   (eff_bits),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign in_ready  = (state_reg == S_IDLE) && !ov_reg;
    assign take      = in_valid && in_ready;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign mul_a     = bfe_pkg::fnv_mul(hash_a_reg ^ {56'd0, in_data.key_byte});
    assign mul_b     = bfe_pkg::fnv_mul(hash_b_reg ^ {56'd0, in_data.key_byte});
    assign bitmask   = 64'd1 << rem_reg[5:0];

    always_comb
    begin
        state_next  = state_reg;
        hash_a_next = hash_a_reg;
        hash_b_next = hash_b_reg;
        sum_next    = sum_reg;
        idx_next    = idx_reg;
        clr_next    = clr_reg;
        mode_next   = mode_reg;
        all_next    = all_reg;
        rem_next    = rem_reg;
        ov_next     = ov_reg;
        od_next     = od_reg;
        mod_start   = 1'b0;
        we          = 1'b0;
        waddr       = AW'(rem_reg >> 6);
        wdata       = rd_reg | bitmask;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_reg[AW-1:0];
                wdata = 64'd0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == WORDS_L - 1'b1)
                begin
                    state_next = S_IDLE;
                    if (mode_reg == bfe_pkg::MODE_CLEAR)
                    begin
                        ov_next = 1'b1;
                        od_next = '{possibly_present: 1'b0, op_done: bfe_pkg::MODE_CLEAR};
                    end
                end
            end
            S_IDLE:
            begin
                if (take)
                begin
                    if (in_data.mode == bfe_pkg::MODE_CLEAR)
                    begin
                        hash_a_next = bfe_pkg::SEED_A;
                        hash_b_next = bfe_pkg::SEED_B;
                        clr_next    = '0;
                        mode_next   = bfe_pkg::MODE_CLEAR;
                        state_next  = S_CLEAR;
                    end
                    else if (in_data.mode != bfe_pkg::MODE_NONE)
                    begin
                        hash_a_next = mul_a;
                        hash_b_next = mul_b;
                        if (in_data.last)
                        begin
                            mode_next  = in_data.mode;
                            sum_next   = mul_a;
                            idx_next   = '0;
                            all_next   = 1'b1;
                            state_next = S_MOD;
                            mod_start  = 1'b1;
                        end
                    end
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    rem_next   = mod_rem;
                    state_next = S_READ;
                end
            end
            S_READ:
                state_next = S_WRITE;
            S_WRITE:
            begin
                if (mode_reg == bfe_pkg::MODE_ADD)
                    we = 1'b1;
                else if ((rd_reg & bitmask) == 64'd0)
                    all_next = 1'b0;
                sum_next = sum_reg + hash_b_reg;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == eff_hashes - 1'b1)
                    state_next = S_OUT;
                else
                begin
                    state_next = S_MOD;
                    mod_start  = 1'b1;
                end
            end
            S_OUT:
            begin
                hash_a_next = bfe_pkg::SEED_A;
                hash_b_next = bfe_pkg::SEED_B;
                ov_next     = 1'b1;
                od_next     = '{possibly_present: (mode_reg == bfe_pkg::MODE_QUERY) && all_reg,
                                op_done: mode_reg};
                state_next  = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_reg <= mem[AW'(rem_next >> 6)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            hash_a_reg <= bfe_pkg::SEED_A;
            hash_b_reg <= bfe_pkg::SEED_B;
            clr_reg    <= '0;
            mode_reg   <= bfe_pkg::MODE_ADD;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            hash_a_reg <= hash_a_next;
            hash_b_reg <= hash_b_next;
            clr_reg    <= clr_next;
            mode_reg   <= mode_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        idx_reg <= idx_next;
        all_reg <= all_next;
        rem_reg <= rem_next;
        od_reg  <= od_next;
    end
endmodule
